// ===== sv/binary_max_heap_assert.svh =====
// Assertion macros used by the heap datapath.
`ifndef BINARY_MAX_HEAP_ASSERT_SVH
`define BINARY_MAX_HEAP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define BMH_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define BMH_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/bmh_pkg.sv =====
package bmh_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;
   localparam logic [OP_W-1:0] OP_BUILD  = 2'd3;

   // Result status codes.
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

   // Memory read address selects.
   localparam logic [2:0] RD_PARENT = 3'd0;
   localparam logic [2:0] RD_LEFT   = 3'd1;
   localparam logic [2:0] RD_RIGHT  = 3'd2;
   localparam logic [2:0] RD_LAST   = 3'd3;
   localparam logic [2:0] RD_K      = 3'd4;

   // Memory write selects.
   localparam logic [1:0] WS_APPEND = 2'd0;
   localparam logic [1:0] WS_VAL    = 2'd1;
   localparam logic [1:0] WS_PARENT = 2'd2;
   localparam logic [1:0] WS_CHILD  = 2'd3;

   typedef struct packed {
      logic            take_in;
      logic [ST_W-1:0] st;
      logic            grow;
      logic            k_init;
      logic            rd_en;
      logic [2:0]      rd_sel;
      logic            wr_en;
      logic [1:0]      wr_sel;
      logic            up_move;
      logic            down_move;
      logic            left_cap;
      logic            take_last;
      logic            take_k;
      logic            out_load;
   } bmh_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic no_child;
      logic has_right;
      logic parent_less;
      logic move_down;
      logic k_zero;
      logic out_busy;
   } bmh_sts_type;

endpackage

// ===== sv/bmh_ctrl.sv =====
module bmh_ctrl import bmh_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_stall,
   input  bmh_sts_type     sts,
   output bmh_cmd_type     cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SU_CHK  = 4'd1;
   localparam logic [3:0] S_SU_CMP  = 4'd2;
   localparam logic [3:0] S_DEL_LD  = 4'd3;
   localparam logic [3:0] S_BLD_CHK = 4'd4;
   localparam logic [3:0] S_BLD_LD  = 4'd5;
   localparam logic [3:0] S_SD_RDL  = 4'd6;
   localparam logic [3:0] S_SD_RDR  = 4'd7;
   localparam logic [3:0] S_SD_CMP  = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       bld_ff, bld_in;
   logic [3:0] sd_done;

   assign req_stall = (state_ff != S_IDLE);

   // A finished sift-down returns to the build loop when a build is running.
   assign sd_done = bld_ff ? S_BLD_CHK : S_FIN;

   always_comb begin
      cmd      = '0;
      cmd.st   = ST_OK;
      state_in = state_ff;
      bld_in   = bld_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_in = 1'b1;
               bld_in      = 1'b0;
               unique case (req_op)
                  OP_INSERT: begin
                     if (sts.full) begin
                        cmd.st   = ST_FULL;
                        state_in = S_FIN;
                     end else begin
                        cmd.grow = 1'b1;
                        state_in = S_SU_CHK;
                     end
                  end
                  OP_LOAD: begin
                     if (sts.full) begin
                        cmd.st = ST_FULL;
                     end else begin
                        cmd.grow   = 1'b1;
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WS_APPEND;
                     end
                     state_in = S_FIN;
                  end
                  OP_DELETE: begin
                     if (sts.empty) begin
                        cmd.st   = ST_EMPTY;
                        state_in = S_FIN;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_LAST;
                        state_in   = S_DEL_LD;
                     end
                  end
                  default: begin
                     cmd.k_init = 1'b1;
                     bld_in     = 1'b1;
                     state_in   = S_BLD_CHK;
                  end
               endcase
            end
         end
         S_SU_CHK: begin
            if (sts.at_root) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WS_VAL;
               state_in   = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.parent_less) begin
               cmd.wr_sel  = WS_PARENT;
               cmd.up_move = 1'b1;
               state_in    = S_SU_CHK;
            end else begin
               cmd.wr_sel = WS_VAL;
               state_in   = S_FIN;
            end
         end
         S_DEL_LD: begin
            cmd.take_last = 1'b1;
            state_in      = S_SD_RDL;
         end
         S_BLD_CHK: begin
            if (sts.k_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_K;
               state_in   = S_BLD_LD;
            end
         end
         S_BLD_LD: begin
            cmd.take_k = 1'b1;
            state_in   = S_SD_RDL;
         end
         S_SD_RDL: begin
            if (sts.no_child) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WS_VAL;
               state_in   = sd_done;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = S_SD_RDR;
            end
         end
         S_SD_RDR: begin
            cmd.left_cap = 1'b1;
            cmd.rd_en    = sts.has_right;
            cmd.rd_sel   = RD_RIGHT;
            state_in     = S_SD_CMP;
         end
         S_SD_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.move_down) begin
               cmd.wr_sel    = WS_CHILD;
               cmd.down_move = 1'b1;
               state_in      = S_SD_RDL;
            end else begin
               cmd.wr_sel = WS_VAL;
               state_in   = sd_done;
            end
         end
         S_FIN: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         bld_ff   <= bld_in;
      end
   end

endmodule

// ===== sv/bmh_dp.sv =====
`include "binary_max_heap_assert.svh"

module bmh_dp import bmh_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [DATA_W-1:0]       req_value,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic signed [DATA_W-1:0]       rsp_removed_value,
   output logic signed [DATA_W-1:0]       rsp_top_value,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_entry_total,
   output logic [ST_W-1:0]                rsp_status,
   input  bmh_cmd_type                    cmd,
   output bmh_sts_type                    sts
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   // Heap index k (1-based) lives at memory address k-1.
   logic signed [DATA_W-1:0] mem [CAPACITY];

   logic [CW-1:0]            cnt_ff, node_ff, k_ff;
   logic signed [DATA_W-1:0] val_ff, left_ff, top_ff, rdata_ff, removed_ff;
   logic [ST_W-1:0]          st_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_removed_ff, rsp_top_ff;
   logic [CW-1:0]            rsp_total_ff;
   logic [ST_W-1:0]          rsp_st_ff;

   logic [CW:0]              child, last, child_pick;
   logic [CW-1:0]            parent, par_m1, node_m1, cnt_m1, k_m1;
   logic [CW:0]              left_m1;
   logic [AW-1:0]            rd_addr, wr_addr;
   logic signed [DATA_W-1:0] wdata, big;
   logic                     pick_right;

   assign child   = {node_ff, 1'b0};
   assign last    = {1'b0, cnt_ff};
   assign parent  = node_ff >> 1;
   assign par_m1  = parent - CW'(1);
   assign node_m1 = node_ff - CW'(1);
   assign cnt_m1  = cnt_ff - CW'(1);
   assign k_m1    = k_ff - CW'(1);
   assign left_m1 = child - (CW+1)'(1);

   // In the compare step the read data holds the right child when there is one.
   assign pick_right = sts.has_right && (rdata_ff > left_ff);
   assign big        = pick_right ? rdata_ff : left_ff;
   assign child_pick = child + {{CW{1'b0}}, pick_right};

   always_comb begin
      sts             = '0;
      sts.full        = (cnt_ff == CW'(CAPACITY));
      sts.empty       = (cnt_ff == '0);
      sts.at_root     = (node_ff == CW'(1));
      sts.no_child    = (child > last);
      sts.has_right   = (child < last);
      sts.parent_less = (rdata_ff < val_ff);
      sts.move_down   = pick_right ? (rdata_ff > val_ff) : (left_ff > val_ff);
      sts.k_zero      = (k_ff == '0);
      sts.out_busy    = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_PARENT: rd_addr = par_m1[AW-1:0];
         RD_LEFT:   rd_addr = left_m1[AW-1:0];
         RD_RIGHT:  rd_addr = child[AW-1:0];
         RD_LAST:   rd_addr = cnt_m1[AW-1:0];
         default:   rd_addr = k_m1[AW-1:0];
      endcase
   end

   always_comb begin
      wr_addr = node_m1[AW-1:0];
      case (cmd.wr_sel)
         WS_APPEND: begin
            wr_addr = cnt_ff[AW-1:0];
            wdata   = req_value;
         end
         WS_VAL:    wdata = val_ff;
         WS_PARENT: wdata = rdata_ff;
         default:   wdata = big;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // The root is mirrored in a register so that every result can report it.
   always_ff @(posedge clock) begin
      if (cmd.wr_en && (wr_addr == '0)) begin
         top_ff <= wdata;
      end
      if (cmd.left_cap) begin
         left_ff <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_in) begin
         val_ff     <= req_value;
         removed_ff <= '0;
         st_ff      <= cmd.st;
      end
      if (cmd.grow) begin
         node_ff <= cnt_ff + CW'(1);
      end
      if (cmd.k_init) begin
         k_ff <= cnt_ff >> 1;
      end
      if (cmd.up_move) begin
         node_ff <= parent;
      end
      if (cmd.down_move) begin
         node_ff <= child_pick[CW-1:0];
      end
      if (cmd.take_last) begin
         val_ff     <= rdata_ff;
         removed_ff <= top_ff;
         node_ff    <= CW'(1);
      end
      if (cmd.take_k) begin
         val_ff  <= rdata_ff;
         node_ff <= k_ff;
         k_ff    <= k_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.grow) begin
         cnt_ff <= cnt_ff + CW'(1);
      end else if (cmd.take_last) begin
         cnt_ff <= cnt_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_removed_ff <= removed_ff;
         rsp_top_ff     <= sts.empty ? '0 : top_ff;
         rsp_total_ff   <= cnt_ff;
         rsp_st_ff      <= st_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_entry_total   = rsp_total_ff;
   assign rsp_status        = rsp_st_ff;

   `BMH_ASSERT(a_cnt_in_range, clock, reset, cnt_ff <= CW'(CAPACITY), "entry count over capacity")
   `BMH_ASSERT(a_load_free, clock, reset, cmd.out_load |-> !(rsp_valid_ff && rsp_stall), "result overwritten while stalled")
   `BMH_ASSERT(a_grow_count, clock, reset, cmd.grow |=> (cnt_ff == $past(cnt_ff) + CW'(1)), "count did not grow")
   `BMH_ASSERT(a_node_valid, clock, reset, (cmd.wr_en && (cmd.wr_sel != WS_APPEND)) |-> (node_ff != '0), "write at heap index zero")
   `BMH_ASSERT(a_grow_not_full, clock, reset, cmd.grow |-> !sts.full, "append into a full heap")

endmodule

// ===== sv/binary_max_heap.sv =====
// Binary max-heap priority queue of signed 32-bit values.
// Input channel req_: req_op selects insert (sift up), delete top, load
// unordered or build (heapify), and req_value carries the value for insert
// and load. An item is taken when req_valid is high and req_stall is low.
// Result channel rsp_: one result per item, with the removed root, the root
// after the operation (zero when empty), the entry count and a status code.
// The block works on one item at a time; req_stall is high from the cycle
// after the accept until the result has been moved into the output register.
// The heap memory is read one entry at a time as the tree is walked level
// by level. A load, a refused insert or load, or a delete on an empty heap
// goes straight to the result. Insert climbs from the new leaf one level at
// a time until the value reaches the root or its parent is not smaller.
// Delete moves the last entry to the root and sifts it down one level at a
// time. Build sifts down each node from count/2 down to 1; an empty build
// goes straight to the result.
// Reset (synchronous) empties the heap; the memory itself is not cleared.
// A stalled result holds in the output register; the next item is accepted
// meanwhile, and its result waits until the output register is taken.
module binary_max_heap import bmh_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [OP_W-1:0]                req_op,
   input  logic signed [DATA_W-1:0]       req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [DATA_W-1:0]       rsp_removed_value,
   output logic signed [DATA_W-1:0]       rsp_top_value,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_entry_total,
   output logic [ST_W-1:0]                rsp_status
);

   bmh_cmd_type cmd;
   bmh_sts_type sts;

   bmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmh_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_removed_value (rsp_removed_value),
      .rsp_top_value     (rsp_top_value),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_status        (rsp_status),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
